FILE: src/dpt_pkg.sv
`timescale 1ns / 1ps

package dpt_pkg;

   localparam int MAC_W  = 48;
   localparam int SEC_W  = 32;
   localparam int RSSI_W = 8;
   localparam int SCORE_W = 7;
   localparam int BONUS_W = 6;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [SEC_W-1:0] TIMEOUT_RESET = 32'd300;
   localparam logic [SEC_W-1:0] SEC_PER_DAY   = 32'd86400;
   localparam logic [SEC_W-1:0] AGE_30_DAYS   = SEC_PER_DAY * 32'd30;
   localparam logic [SEC_W-1:0] AGE_14_DAYS   = SEC_PER_DAY * 32'd14;
   localparam logic [SEC_W-1:0] AGE_7_DAYS    = SEC_PER_DAY * 32'd7;
   localparam logic [SEC_W-1:0] AGE_3_DAYS    = SEC_PER_DAY * 32'd3;

   localparam logic [BONUS_W-1:0] BONUS_30_DAYS = 6'd40;
   localparam logic [BONUS_W-1:0] BONUS_14_DAYS = 6'd30;
   localparam logic [BONUS_W-1:0] BONUS_7_DAYS  = 6'd20;
   localparam logic [BONUS_W-1:0] BONUS_3_DAYS  = 6'd10;

   localparam logic [SCORE_W-1:0] SCORE_BASE    = 7'd10;
   localparam logic [SCORE_W-1:0] SCORE_HISTORY = 7'd20;
   localparam logic [SCORE_W-1:0] SCORE_MAX     = 7'd100;
   localparam logic [SCORE_W-1:0] TRACK_LEVEL   = 7'd50;

   // register index taken from paddr[2]
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_EVENTS  = 1'b1;

   typedef enum logic [1:0] {
      OP_SIGHTING = 2'd0,
      OP_SCAN     = 2'd1,
      OP_RESTORE  = 2'd2,
      OP_QUERY    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_FIRST    = 3'd1,
      EV_ARRIVED  = 3'd2,
      EV_LEFT     = 3'd3,
      EV_RETURNED = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [SEC_W-1:0] last_seen;
      logic             present;
      logic             history;
   } entry_type;

   typedef struct packed {
      logic                     status;
      event_kind_type           event_kind;
      logic [MAC_W-1:0]         event_mac;
      logic signed [RSSI_W-1:0] event_rssi;
      logic [SCORE_W-1:0]       trust_score;
      logic                     is_tracked;
      logic                     is_present;
      logic                     last_result;
   } result_type;

   typedef struct packed {
      logic [SEC_W-1:0] timeout;
      logic             events_en;
   } cfg_type;

   typedef struct packed {
      logic               late;
      logic [BONUS_W-1:0] bonus;
   } age_res_type;

endpackage

FILE: src/dpt_channels_if.sv
`timescale 1ns / 1ps

interface dpt_req_if;
   import dpt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [MAC_W-1:0]         device_mac;
   logic [SEC_W-1:0]         now_sec;
   logic signed [RSSI_W-1:0] signal_rssi;

   modport source(output valid, opcode, device_mac, now_sec, signal_rssi, input ready);
   modport sink(input valid, opcode, device_mac, now_sec, signal_rssi, output ready);
endinterface

interface dpt_rsp_if;
   import dpt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     status;
   logic [2:0]               event_kind;
   logic [MAC_W-1:0]         event_mac;
   logic signed [RSSI_W-1:0] event_rssi;
   logic [SCORE_W-1:0]       trust_score;
   logic                     is_tracked;
   logic                     is_present;
   logic                     last_result;

   modport source(output valid, status, event_kind, event_mac, event_rssi, trust_score,
                  is_tracked, is_present, last_result, input ready);
   modport sink(input valid, status, event_kind, event_mac, event_rssi, trust_score,
                is_tracked, is_present, last_result, output ready);
endinterface

FILE: src/device_presence_tracker_unit.sv
`timescale 1ns / 1ps

// Device presence tracker.
// req channel: one transaction per operation (sighting, departure scan, restore, query).
// rsp channel: result transactions; last_result marks the final one of an operation.
// Sightings, restores and queries give one result; a departure scan gives one result
// per device that left, in table order (events on), or a single empty result.
// APB port: presence timeout at 0x0, event enable at 0x4; write only while idle.
// The table is a single-port-read memory walked by a sequencer that shares one age
// subtract/compare unit, one entry per cycle except while a stalled receiver holds a scan.
// An operation reads N entries (up to the fill count, TABLE_DEPTH at most), and ready
// is low for the whole operation.
// A result waits in an output register; a stalled receiver holds the scan at the next
// departing entry while one more result is pending, and the next transaction can be
// accepted while the final result still waits.
// Reset empties the table by clearing the fill count and restores the registers to
// timeout 300 and events on. No clearing pass is needed.
module device_presence_tracker_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   dpt_req_if.sink                      req,
   dpt_rsp_if.source                    rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dpt_pkg::PADDR_W-1:0] paddr,
   input  logic [dpt_pkg::PDATA_W-1:0] pwdata,
   output logic [dpt_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   import dpt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MISS,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   opcode_type               op_ff, op_in;
   logic [MAC_W-1:0]         mac_ff, mac_in;
   logic [SEC_W-1:0]         now_ff, now_in;
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     pend_valid_ff, pend_valid_in;
   result_type               pend_ff, pend_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_ff, out_in;

   cfg_type          cfg;
   entry_type        rd_entry;
   entry_type        wr_entry;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] rd_addr;
   age_res_type      age_res;

   logic [CNT_W-1:0] idx_next;
   logic             is_last;
   logic             out_free;
   logic             leaving;
   event_kind_type   sight_kind;

   function automatic result_type make_result(
      input logic                     status,
      input event_kind_type           kind,
      input logic [MAC_W-1:0]         mac,
      input logic signed [RSSI_W-1:0] rssi,
      input logic [SCORE_W-1:0]       score,
      input logic                     present
   );
      result_type r;
      r.status      = status;
      r.event_kind  = kind;
      r.event_mac   = mac;
      r.is_present  = present;
      r.last_result = 1'b0;
      if (kind == EV_NONE) begin
         r.event_rssi  = '0;
         r.trust_score = '0;
         r.is_tracked  = 1'b0;
      end else begin
         r.event_rssi  = rssi;
         r.trust_score = score;
         r.is_tracked  = (score > TRACK_LEVEL);
      end
      return r;
   endfunction

   function automatic logic [SCORE_W-1:0] left_score(
      input logic               history,
      input logic [BONUS_W-1:0] bonus
   );
      logic [SCORE_W-1:0] s;
      s = SCORE_BASE;
      if (history) begin
         s = SCORE_BASE + SCORE_HISTORY + SCORE_W'(bonus);
      end
      if (s > SCORE_MAX) begin
         s = SCORE_MAX;
      end
      return s;
   endfunction

   dpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dpt_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (wr_entry),
      .raddr (rd_addr),
      .rdata (rd_entry)
   );

   dpt_age_unit u_age (
      .now_sec   (now_ff),
      .last_seen (rd_entry.last_seen),
      .timeout   (cfg.timeout),
      .res       (age_res)
   );

   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign is_last  = (idx_next == count_ff);
   assign out_free = !out_valid_ff || rsp.ready;
   assign leaving  = rd_entry.present && age_res.late;

   always_comb begin
      if (!rd_entry.history) begin
         sight_kind = EV_FIRST;
      end else if (!rd_entry.present) begin
         sight_kind = age_res.late ? EV_RETURNED : EV_ARRIVED;
      end else begin
         sight_kind = EV_NONE;
      end
      if (!cfg.events_en) begin
         sight_kind = EV_NONE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      mac_in        = mac_ff;
      now_in        = now_ff;
      rssi_in       = rssi_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      wr_entry      = rd_entry;
      rd_addr       = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req.valid) begin
               op_in         = opcode_type'(req.opcode);
               mac_in        = req.device_mac;
               now_in        = req.now_sec;
               rssi_in       = req.signal_rssi;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               if (count_ff == '0) begin
                  state_in = (opcode_type'(req.opcode) == OP_SCAN) ? ST_FINISH : ST_MISS;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (op_ff == OP_SCAN) begin
               if (leaving && cfg.events_en && pend_valid_ff && !out_free) begin
                  // hold: result slot busy, re-read the same entry
                  rd_addr = idx_ff;
               end else begin
                  if (leaving) begin
                     mem_we           = 1'b1;
                     wr_entry.present = 1'b0;
                     if (cfg.events_en) begin
                        if (pend_valid_ff) begin
                           out_valid_in = 1'b1;
                           out_in       = pend_ff;
                        end
                        pend_valid_in = 1'b1;
                        pend_in = make_result(1'b0, EV_LEFT, rd_entry.mac, '0,
                                              left_score(rd_entry.history, age_res.bonus),
                                              1'b0);
                     end
                  end
                  if (is_last) begin
                     state_in = ST_FINISH;
                  end else begin
                     idx_in  = idx_next[IDX_W-1:0];
                     rd_addr = idx_next[IDX_W-1:0];
                  end
               end
            end else if (rd_entry.mac == mac_ff) begin
               pend_valid_in = 1'b1;
               state_in      = ST_FINISH;
               unique case (op_ff)
                  OP_SIGHTING: begin
                     mem_we   = 1'b1;
                     wr_entry = '{mac: mac_ff, last_seen: now_ff, present: 1'b1,
                                  history: 1'b1};
                     pend_in  = make_result(1'b0, sight_kind, mac_ff, rssi_ff,
                                            (sight_kind == EV_FIRST) ? SCORE_BASE
                                                : SCORE_BASE + SCORE_HISTORY,
                                            1'b0);
                  end
                  OP_RESTORE: begin
                     mem_we   = 1'b1;
                     wr_entry = '{mac: mac_ff, last_seen: '0, present: 1'b0, history: 1'b1};
                     pend_in  = make_result(1'b0, EV_NONE, mac_ff, '0, '0, 1'b0);
                  end
                  default: begin
                     pend_in = make_result(1'b0, EV_NONE, mac_ff, '0, '0, !age_res.late);
                  end
               endcase
            end else if (is_last) begin
               state_in = ST_MISS;
            end else begin
               idx_in  = idx_next[IDX_W-1:0];
               rd_addr = idx_next[IDX_W-1:0];
            end
         end

         ST_MISS: begin
            pend_valid_in = 1'b1;
            state_in      = ST_FINISH;
            mem_waddr     = count_ff[IDX_W-1:0];
            if (op_ff == OP_QUERY) begin
               pend_in = make_result(1'b0, EV_NONE, mac_ff, '0, '0, 1'b0);
            end else if (count_ff == FULL_COUNT) begin
               pend_in = make_result(1'b1, EV_NONE, mac_ff, '0, '0, 1'b0);
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (op_ff == OP_SIGHTING) begin
                  wr_entry = '{mac: mac_ff, last_seen: now_ff, present: 1'b1, history: 1'b1};
                  pend_in  = make_result(1'b0, cfg.events_en ? EV_FIRST : EV_NONE, mac_ff,
                                         rssi_ff, SCORE_BASE, 1'b0);
               end else begin
                  wr_entry = '{mac: mac_ff, last_seen: '0, present: 1'b0, history: 1'b1};
                  pend_in  = make_result(1'b0, EV_NONE, mac_ff, '0, '0, 1'b0);
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = pend_valid_ff ? pend_ff
                                            : make_result(1'b0, EV_NONE, '0, '0, '0, 1'b0);
               out_in.last_result = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      op_ff   <= op_in;
      mac_ff  <= mac_in;
      now_ff  <= now_in;
      rssi_ff <= rssi_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.status      = out_ff.status;
   assign rsp.event_kind  = 3'(out_ff.event_kind);
   assign rsp.event_mac   = out_ff.event_mac;
   assign rsp.event_rssi  = out_ff.event_rssi;
   assign rsp.trust_score = out_ff.trust_score;
   assign rsp.is_tracked  = out_ff.is_tracked;
   assign rsp.is_present  = out_ff.is_present;
   assign rsp.last_result = out_ff.last_result;

endmodule

FILE: src/dpt_csr.sv
`timescale 1ns / 1ps

module dpt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [dpt_pkg::PADDR_W-1:0] paddr,
   input  logic [dpt_pkg::PDATA_W-1:0] pwdata,
   output logic [dpt_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output dpt_pkg::cfg_type             cfg
);
   import dpt_pkg::*;

   logic [SEC_W-1:0] timeout_ff, timeout_in;
   logic             events_ff, events_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      events_in  = events_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_TIMEOUT: timeout_in = pwdata[SEC_W-1:0];
            REG_EVENTS:  events_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TIMEOUT: prdata = PDATA_W'(timeout_ff);
         REG_EVENTS:  prdata = PDATA_W'(events_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         events_ff  <= 1'b1;
      end else begin
         timeout_ff <= timeout_in;
         events_ff  <= events_in;
      end
   end

   assign cfg.timeout   = timeout_ff;
   assign cfg.events_en = events_ff;

endmodule

FILE: src/dpt_table.sv
`timescale 1ns / 1ps

module dpt_table #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                we,
   input  logic [IDX_W-1:0]    waddr,
   input  dpt_pkg::entry_type  wdata,
   input  logic [IDX_W-1:0]    raddr,
   output dpt_pkg::entry_type  rdata
);
   import dpt_pkg::*;

   entry_type entry_ff [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         entry_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= entry_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

FILE: src/dpt_age_unit.sv
`timescale 1ns / 1ps

module dpt_age_unit (
   input  logic [dpt_pkg::SEC_W-1:0] now_sec,
   input  logic [dpt_pkg::SEC_W-1:0] last_seen,
   input  logic [dpt_pkg::SEC_W-1:0] timeout,
   output dpt_pkg::age_res_type      res
);
   import dpt_pkg::*;

   logic [SEC_W-1:0] age;

   // age wraps modulo 2^32
   assign age = now_sec - last_seen;

   always_comb begin
      res.late = (age >= timeout);
      if (age >= AGE_30_DAYS) begin
         res.bonus = BONUS_30_DAYS;
      end else if (age >= AGE_14_DAYS) begin
         res.bonus = BONUS_14_DAYS;
      end else if (age >= AGE_7_DAYS) begin
         res.bonus = BONUS_7_DAYS;
      end else if (age >= AGE_3_DAYS) begin
         res.bonus = BONUS_3_DAYS;
      end else begin
         res.bonus = '0;
      end
   end

endmodule

FILE: src/dpt_checker.sv
`timescale 1ns / 1ps

module dpt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_event_kind,
   input logic [dpt_pkg::SCORE_W-1:0] rsp_trust_score,
   input logic                         rsp_is_tracked,
   input logic                         rsp_last_result
);
   import dpt_pkg::*;

   // a pending result stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   // no new transaction once one was taken until the sequencer is back
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted on consecutive cycles");

   // a scan in progress keeps the request side closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("req ready while a multi-result operation is open");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_tracked == (rsp_trust_score > TRACK_LEVEL)) &&
                    (rsp_event_kind != 3'(EV_NONE) || rsp_trust_score == '0))
      else $error("trust score and tracked flag disagree");

endmodule

bind device_presence_tracker_unit dpt_checker u_dpt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_event_kind  (rsp.event_kind),
   .rsp_trust_score (rsp.trust_score),
   .rsp_is_tracked  (rsp.is_tracked),
   .rsp_last_result (rsp.last_result)
);
